/* rtl/lfbf_pkg.sv */
// Package with shared types, constants and codes for the line framing byte FIFO.
package lfbf_pkg;

	localparam int STORE_DEPTH    = 4096;
	localparam int MAX_LINE_BYTES = 512;
	localparam int PTR_W          = $clog2(STORE_DEPTH);
	localparam int LVL_W          = 13;
	localparam int CNT_W          = 13;
	localparam int LINE_W         = $clog2(MAX_LINE_BYTES + 1);

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	typedef enum logic [1:0] {
		CMD_PUT    = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_GET    = 2'd2,
		CMD_LINE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_OVERF   = 2'd1,
		ST_DROPPED = 2'd2,
		ST_NOLINE  = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [7:0]       data_byte;
		logic             end_of_put;
		logic [CNT_W-1:0] count;
	} in_req_t;

	typedef struct packed {
		logic [63:0]      word;
		logic [3:0]       bytes_in_word;
		logic             last;
		logic [1:0]       status;
		logic [LVL_W-1:0] level;
	} out_req_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_STRIP_RD,
		S_STRIP_CHK,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_PACK_RD,
		S_PACK_CHK,
		S_TAIL_RD,
		S_TAIL_CHK,
		S_EMIT
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic    take;       // latch the accepted request
		logic    do_put;     // perform put logic on the latched request
		logic    do_delete;
		logic    rd_at_off;  // issue a memory read at head + offset
		logic    off_inc;    // step the scan offset
		logic    off_clr;
		logic    mark_n;     // the offset is the line length
		logic    mark_end;   // the offset is the total to consume; restart at head
		logic    pop_head;   // consume one byte at head
		logic    shift_in;   // add read byte to the packing word
		logic    consume_n;  // consume the recorded total from head
		logic    set_single; // prepare a single result with given status
		status_t status;
		logic    set_word;   // prepare a data word result
		logic    word_last;
		logic    out_load;   // move prepared result into the output register
	} ctl_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic [1:0] cmd;
		logic       is_eol;    // byte read last cycle is CR or LF
		logic       lvl_zero;
		logic       off_at_win;
		logic       off_at_lvl;
		logic       off_at_n;
		logic       word_full;
		logic       out_busy;
		logic       n_zero;
	} dp_stat_t;

endpackage

/* rtl/lfbf_ctrl.sv */
// Controller state machine sequencing the FIFO commands.
module lfbf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  lfbf_pkg::dp_stat_t    stat,
	output lfbf_pkg::ctl_cmd_t    cmd
);
	import lfbf_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE) || stat.out_busy;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && !stat.out_busy) state_d = S_EMIT;
			end
			S_EMIT: begin
				unique case (stat.cmd)
					CMD_PUT: state_d = S_IDLE;
					CMD_DELETE: state_d = S_IDLE;
					CMD_GET: state_d = stat.n_zero ? S_IDLE : S_PACK_RD;
					CMD_LINE: state_d = S_STRIP_RD;
				endcase
			end
			S_STRIP_RD: state_d = stat.lvl_zero ? S_SCAN_RD : S_STRIP_CHK;
			S_STRIP_CHK: state_d = stat.is_eol ? S_STRIP_RD : S_SCAN_RD;
			S_SCAN_RD: state_d = stat.off_at_win ? S_IDLE : S_SCAN_CHK;
			S_SCAN_CHK: begin
				if (stat.is_eol) state_d = stat.n_zero ? S_IDLE : S_TAIL_RD;
				else state_d = S_SCAN_RD;
			end
			S_TAIL_RD: state_d = stat.off_at_lvl ? S_PACK_RD : S_TAIL_CHK;
			S_TAIL_CHK: state_d = stat.is_eol ? S_TAIL_RD : S_PACK_RD;
			S_PACK_RD: state_d = S_PACK_CHK;
			S_PACK_CHK: begin
				if (stat.out_busy) state_d = S_PACK_CHK;
				else if (stat.off_at_n) state_d = S_IDLE;
				else state_d = S_PACK_RD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.status = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				cmd.take = in_valid && !stat.out_busy;
			end
			S_EMIT: begin
				cmd.off_clr = 1'b1;
				unique case (stat.cmd)
					CMD_PUT: begin
						cmd.do_put = 1'b1;
						cmd.out_load = 1'b1;
					end
					CMD_DELETE: begin
						cmd.do_delete = 1'b1;
						cmd.set_single = 1'b1;
						cmd.out_load = 1'b1;
					end
					CMD_GET: begin
						if (stat.n_zero) begin
							cmd.set_single = 1'b1;
							cmd.out_load = 1'b1;
						end
					end
					CMD_LINE: ;
				endcase
			end
			S_STRIP_RD: cmd.rd_at_off = !stat.lvl_zero;
			S_STRIP_CHK: begin
				cmd.pop_head = stat.is_eol;
			end
			S_SCAN_RD: begin
				cmd.rd_at_off = !stat.off_at_win;
				if (stat.off_at_win) begin
					cmd.set_single = 1'b1;
					cmd.status = ST_NOLINE;
					cmd.out_load = 1'b1;
				end
			end
			S_SCAN_CHK: begin
				if (stat.is_eol) begin
					if (stat.n_zero) begin
						cmd.set_single = 1'b1;
						cmd.status = ST_NOLINE;
						cmd.out_load = 1'b1;
					end else begin
						cmd.mark_n = 1'b1;
						cmd.off_inc = 1'b1;
					end
				end else begin
					cmd.off_inc = 1'b1;
				end
			end
			S_TAIL_RD: begin
				cmd.rd_at_off = !stat.off_at_lvl;
				cmd.mark_end = stat.off_at_lvl;
			end
			S_TAIL_CHK: begin
				cmd.off_inc = stat.is_eol;
				cmd.mark_end = !stat.is_eol;
			end
			S_PACK_RD: cmd.rd_at_off = 1'b1;
			S_PACK_CHK: begin
				if (!stat.out_busy) begin
					cmd.shift_in = 1'b1;
					cmd.off_inc = 1'b1;
					if (stat.word_full || stat.off_at_n) begin
						cmd.set_word = 1'b1;
						cmd.word_last = stat.off_at_n;
						cmd.out_load = 1'b1;
					end
					cmd.consume_n = stat.off_at_n;
				end
			end
			default: ;
		endcase
	end

	no_take_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> state_q == S_IDLE)
		else $error("request taken outside idle");
	pop_only_on_eol: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_head |-> stat.is_eol)
		else $error("popped a non line-end byte");
	load_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && state_q == S_PACK_CHK) |-> !stat.out_busy)
		else $error("output overwritten");

endmodule

/* rtl/lfbf_datapath.sv */
// Datapath: ring memory, pointers, fill level, packing and output register.
module lfbf_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [lfbf_pkg::LVL_W-1:0] cfg_data,
	input  lfbf_pkg::in_req_t     in_req,
	input  lfbf_pkg::ctl_cmd_t    cmd,
	output lfbf_pkg::dp_stat_t    stat,
	output logic                  out_valid,
	input  logic                  out_stall,
	output lfbf_pkg::out_req_t    out_req
);
	import lfbf_pkg::*;

	logic [7:0]       mem [STORE_DEPTH];
	logic [7:0]       rd_q;
	logic [LVL_W-1:0] cap_q;
	logic [PTR_W-1:0] rp_q;
	logic [LVL_W-1:0] lvl_q;
	logic             drop_q;
	in_req_t          req_q;
	logic [LVL_W-1:0] off_q;     // offset from the head for scans and packing
	logic [LVL_W-1:0] n_q;       // bytes to pack
	logic [LVL_W-1:0] end_q;     // bytes consumed when the command ends
	logic [2:0]       wb_q;      // bytes in the packing word
	logic [63:0]      wacc_q;
	out_req_t         res_q;
	logic             ov_q;

	logic [LVL_W-1:0] cap_eff, del_n, win, lvl_res;
	logic [LINE_W-1:0] cnt_cl;
	logic [PTR_W-1:0] wr_addr, rd_addr;
	logic             full;
	logic [63:0]      wnext;
	status_t          put_st;

	assign cap_eff = (cap_q > LVL_W'(STORE_DEPTH)) ? LVL_W'(STORE_DEPTH) : cap_q;
	assign full    = lvl_q >= cap_eff;
	assign del_n   = (req_q.count > lvl_q) ? lvl_q : req_q.count;
	assign cnt_cl  = (req_q.count > CNT_W'(MAX_LINE_BYTES)) ? LINE_W'(MAX_LINE_BYTES)
		: LINE_W'(req_q.count);
	assign win     = (LVL_W'(cnt_cl) < lvl_q) ? LVL_W'(cnt_cl) : lvl_q;
	assign wr_addr = rp_q + PTR_W'(lvl_q);
	assign rd_addr = rp_q + PTR_W'(off_q);

	always_ff @(posedge clk) begin
		if (cmd.do_put && !drop_q && !full) mem[wr_addr] <= req_q.data_byte;
		if (cmd.rd_at_off) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= LVL_W'(STORE_DEPTH);
			rp_q   <= '0;
			lvl_q  <= '0;
			drop_q <= 1'b0;
			off_q  <= '0;
			n_q    <= '0;
			end_q  <= '0;
			wb_q   <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (cfg_we) cap_q <= cfg_data;
			if (cmd.take && in_req.cmd != CMD_PUT) drop_q <= 1'b0;
			if (cmd.off_clr) begin
				off_q <= '0;
				wb_q  <= '0;
				n_q   <= win;
				end_q <= win;
			end else if (cmd.mark_end) begin
				// The trailing line-end run is known; packing restarts at the head.
				off_q <= '0;
				wb_q  <= '0;
				end_q <= off_q;
			end else if (cmd.off_inc) begin
				off_q <= off_q + LVL_W'(1);
				if (cmd.shift_in) wb_q <= wb_q + 3'd1;
			end
			if (cmd.mark_n) n_q <= off_q;
			if (cmd.do_put) begin
				if (drop_q) begin
					if (req_q.end_of_put) drop_q <= 1'b0;
				end else if (full) begin
					lvl_q  <= '0;
					rp_q   <= '0;
					drop_q <= !req_q.end_of_put;
				end else begin
					lvl_q <= lvl_q + LVL_W'(1);
				end
			end else if (cmd.do_delete) begin
				lvl_q <= lvl_q - del_n;
				rp_q  <= (lvl_q == del_n) ? '0 : rp_q + PTR_W'(del_n);
			end else if (cmd.pop_head) begin
				lvl_q <= lvl_q - LVL_W'(1);
				rp_q  <= (lvl_q == LVL_W'(1)) ? '0 : rp_q + PTR_W'(1);
			end else if (cmd.consume_n) begin
				lvl_q <= lvl_q - end_q;
				rp_q  <= (lvl_q == end_q) ? '0 : rp_q + PTR_W'(end_q);
			end
			if (cmd.out_load) ov_q <= 1'b1;
			else if (ov_q && !out_stall) ov_q <= 1'b0;
		end
	end

	assign wnext = (wb_q == 3'd0 ? 64'd0 : wacc_q) | (64'(rd_q) << {wb_q, 3'b000});

	always_ff @(posedge clk) begin
		if (cmd.shift_in) wacc_q <= wnext;
	end

	assign put_st = drop_q ? ST_DROPPED : (full ? ST_OVERF : ST_OK);

	// Every result of a command carries the level that the command leaves.
	always_comb begin
		priority if (cmd.do_put) lvl_res = drop_q ? lvl_q : (full ? '0 : lvl_q + LVL_W'(1));
		else if (cmd.do_delete) lvl_res = lvl_q - del_n;
		else if (cmd.set_word) lvl_res = lvl_q - end_q;
		else lvl_res = lvl_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q.level <= lvl_res;
			if (cmd.set_word) begin
				res_q.word <= wnext;
				res_q.bytes_in_word <= 4'(wb_q) + 4'd1;
				res_q.last <= cmd.word_last;
				res_q.status <= ST_OK;
			end else begin
				res_q.word <= '0;
				res_q.bytes_in_word <= '0;
				res_q.last <= 1'b1;
				res_q.status <= cmd.do_put ? put_st : cmd.status;
			end
		end
	end

	assign out_req   = res_q;
	assign out_valid = ov_q;

	always_comb begin
		stat.cmd        = req_q.cmd;
		stat.is_eol     = rd_q == CHAR_CR || rd_q == CHAR_LF;
		stat.lvl_zero   = lvl_q == '0;
		stat.off_at_win = off_q == win;
		stat.off_at_lvl = off_q == lvl_q;
		stat.off_at_n   = off_q + LVL_W'(1) == n_q;
		stat.word_full  = wb_q == 3'd7;
		stat.out_busy   = ov_q && out_stall;
		stat.n_zero     = (req_q.cmd == CMD_GET) ? (win == '0) : (off_q == '0);
	end

	always_ff @(posedge clk) begin
		if (cmd.take) req_q <= in_req;
	end

	out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_stall) |=> ov_q)
		else $error("result lost while stalled");
	level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q <= LVL_W'(STORE_DEPTH))
		else $error("level beyond store");
	empty_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(lvl_q == '0) |-> rp_q == '0)
		else $error("pointer not reset when empty");

endmodule

/* rtl/line_framing_byte_fifo_core.sv */
// Top level of the line framing byte FIFO: controller plus datapath.
//
//  channel   direction  handshake           payload
//  in        into core  in_valid/in_stall   in_req (cmd, data_byte, end_of_put, count)
//  out       from core  out_valid/out_stall out_req (word, bytes_in_word, last, status, level)
//  cfg       into core  cfg_we              cfg_data (capacity_bytes)
//
// A put or delete is taken in the idle state; in the emit state it updates
// state and loads the result register. The next request is taken in the cycle
// in which the result leaves; no request is taken while one is in progress.
// A get reads its bytes one at a time through the single read port of the
// ring memory. A line read passes a read and a check state on each stripped
// leading line-end byte, scanned byte, trailing line-end byte and packed byte.
// Reset clears pointers, level and the drop flag; the store needs no clearing.
// A stalled result blocks further requests and holds the packing loop.
module line_framing_byte_fifo_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [12:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  lfbf_pkg::in_req_t     in_req,
	output logic                  out_valid,
	input  logic                  out_stall,
	output lfbf_pkg::out_req_t    out_req
);
	import lfbf_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	// The controller walks each request through its steps.
	lfbf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the memory and produces the result words.
	lfbf_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_req    (in_req),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_req   (out_req)
	);

endmodule
